[rtl/string_escape_decoder_macros.svh]
`ifndef STRING_ESCAPE_DECODER_MACROS_SVH
`define STRING_ESCAPE_DECODER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SED_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sed_pkg.sv]
package sed_pkg;

  localparam int SED_FIFO_DEPTH = 4;
  localparam int SED_SLOTS      = 3;

  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_DQUOTE = 8'h22;
  localparam logic [7:0] CHR_BTICK  = 8'h60;
  localparam logic [7:0] CHR_N      = 8'h6E;
  localparam logic [7:0] CHR_R      = 8'h72;
  localparam logic [7:0] CHR_T      = 8'h74;
  localparam logic [7:0] CHR_F      = 8'h66;
  localparam logic [7:0] CHR_V      = 8'h76;
  localparam logic [7:0] CHR_X_LO   = 8'h78;
  localparam logic [7:0] CHR_X_UP   = 8'h58;
  localparam logic [7:0] CHR_0      = 8'h30;
  localparam logic [7:0] CHR_7      = 8'h37;
  localparam logic [7:0] CHR_9      = 8'h39;
  localparam logic [7:0] CHR_A_UP   = 8'h41;
  localparam logic [7:0] CHR_F_UP   = 8'h46;
  localparam logic [7:0] CHR_A_LO   = 8'h61;
  localparam logic [7:0] CHR_F_LO   = 8'h66;

  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_HT = 8'h09;
  localparam logic [7:0] BYTE_FF = 8'h0C;
  localparam logic [7:0] BYTE_VT = 8'h0B;

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_ESC   = 3'd1,
    MODE_HEX0  = 3'd2,
    MODE_HEX1  = 3'd3,
    MODE_OCT1  = 3'd4,
    MODE_OCT2  = 3'd5
  } sed_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       eos;
  } sed_slot_t;

  // one decoded input transaction: cnt results in slot[0..cnt-1]
  typedef struct packed {
    logic [1:0]                    cnt;
    sed_slot_t [SED_SLOTS-1:0]     slot;
  } sed_entry_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } sed_hex_t;

  function automatic sed_hex_t hex_decode(input logic [7:0] c);
    sed_hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= CHR_0 && c <= CHR_9) begin
      h.val = 4'(c - CHR_0);
    end else if (c >= CHR_A_UP && c <= CHR_F_UP) begin
      h.val = 4'(c - CHR_A_UP + 8'd10);
    end else if (c >= CHR_A_LO && c <= CHR_F_LO) begin
      h.val = 4'(c - CHR_A_LO + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= CHR_0) && (c <= CHR_7);
  endfunction

  function automatic sed_slot_t mk_slot(input logic [7:0] d, input logic v,
                                        input logic e);
    sed_slot_t s;
    s.data  = d;
    s.valid = v;
    s.eos   = e;
    return s;
  endfunction

endpackage

[rtl/sed_front.sv]
module sed_front
  import sed_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] in_char,
  input  logic       end_mark,
  output logic       push,
  output sed_entry_t ent
);

  sed_mode_t  mode_r, mode_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic [1:0] n;
  logic       do_plain;
  sed_hex_t   hv;

  always_comb begin
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    ent      = '0;
    n        = 2'd0;
    do_plain = 1'b0;
    hv       = hex_decode(in_char);
    if (end_mark) begin
      case (mode_r)
        MODE_ESC: begin
          ent.slot[n] = mk_slot(CHR_BSLASH, 1'b1, 1'b0); n = n + 2'd1;
        end
        MODE_HEX0: begin
          ent.slot[n] = mk_slot(CHR_BSLASH, 1'b1, 1'b0); n = n + 2'd1;
          ent.slot[n] = mk_slot(pend_r, 1'b1, 1'b0);     n = n + 2'd1;
        end
        MODE_HEX1, MODE_OCT1, MODE_OCT2: begin
          ent.slot[n] = mk_slot(pend_r, 1'b1, 1'b0); n = n + 2'd1;
        end
        default: ;
      endcase
      ent.slot[n] = mk_slot(8'h00, 1'b0, 1'b1); n = n + 2'd1;
      mode_nxt = MODE_PLAIN;
      pend_nxt = 8'h00;
    end else begin
      case (mode_r)
        MODE_ESC: begin
          mode_nxt = MODE_PLAIN;
          case (in_char)
            CHR_N: begin ent.slot[n] = mk_slot(BYTE_LF, 1'b1, 1'b0); n = n + 2'd1; end
            CHR_R: begin ent.slot[n] = mk_slot(BYTE_CR, 1'b1, 1'b0); n = n + 2'd1; end
            CHR_T: begin ent.slot[n] = mk_slot(BYTE_HT, 1'b1, 1'b0); n = n + 2'd1; end
            CHR_F: begin ent.slot[n] = mk_slot(BYTE_FF, 1'b1, 1'b0); n = n + 2'd1; end
            CHR_V: begin ent.slot[n] = mk_slot(BYTE_VT, 1'b1, 1'b0); n = n + 2'd1; end
            CHR_DQUOTE, CHR_BTICK, CHR_BSLASH: begin
              ent.slot[n] = mk_slot(in_char, 1'b1, 1'b0); n = n + 2'd1;
            end
            CHR_X_LO, CHR_X_UP: begin
              mode_nxt = MODE_HEX0;
              pend_nxt = in_char;
            end
            default: begin
              if (is_oct(in_char)) begin
                mode_nxt = MODE_OCT1;
                pend_nxt = {5'd0, in_char[2:0]};
              end else begin
                ent.slot[n] = mk_slot(CHR_BSLASH, 1'b1, 1'b0); n = n + 2'd1;
                ent.slot[n] = mk_slot(in_char, 1'b1, 1'b0);    n = n + 2'd1;
              end
            end
          endcase
        end
        MODE_HEX0: begin
          if (hv.ok) begin
            mode_nxt = MODE_HEX1;
            pend_nxt = {4'd0, hv.val};
          end else begin
            ent.slot[n] = mk_slot(CHR_BSLASH, 1'b1, 1'b0); n = n + 2'd1;
            ent.slot[n] = mk_slot(pend_r, 1'b1, 1'b0);     n = n + 2'd1;
            do_plain = 1'b1;
          end
        end
        MODE_HEX1: begin
          if (hv.ok) begin
            ent.slot[n] = mk_slot({pend_r[3:0], hv.val}, 1'b1, 1'b0); n = n + 2'd1;
            mode_nxt = MODE_PLAIN;
          end else begin
            ent.slot[n] = mk_slot(pend_r, 1'b1, 1'b0); n = n + 2'd1;
            do_plain = 1'b1;
          end
        end
        MODE_OCT1: begin
          if (is_oct(in_char)) begin
            pend_nxt = {pend_r[4:0], in_char[2:0]};
            mode_nxt = MODE_OCT2;
          end else begin
            ent.slot[n] = mk_slot(pend_r, 1'b1, 1'b0); n = n + 2'd1;
            do_plain = 1'b1;
          end
        end
        MODE_OCT2: begin
          if (is_oct(in_char)) begin
            ent.slot[n] = mk_slot({pend_r[4:0], in_char[2:0]}, 1'b1, 1'b0);
            n = n + 2'd1;
            mode_nxt = MODE_PLAIN;
          end else begin
            ent.slot[n] = mk_slot(pend_r, 1'b1, 1'b0); n = n + 2'd1;
            do_plain = 1'b1;
          end
        end
        default: do_plain = 1'b1;
      endcase
      if (do_plain) begin
        if (in_char == CHR_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else begin
          mode_nxt = MODE_PLAIN;
          ent.slot[n] = mk_slot(in_char, 1'b1, 1'b0); n = n + 2'd1;
        end
      end
    end
    ent.cnt = n;
  end

  assign push = acc && (n != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      pend_r <= 8'h00;
    end else if (acc) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

[rtl/sed_fifo.sv]
module sed_fifo
  import sed_pkg::*;
#(
  parameter int DEPTH = SED_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  sed_entry_t wr_ent,
  output logic       full,
  input  logic       pop,
  output logic       rd_valid,
  output sed_entry_t rd_ent
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sed_entry_t       q_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_ent   = q_r[rptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wptr_r] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[rtl/sed_back.sv]
module sed_back
  import sed_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       hd_valid,
  input  sed_entry_t hd_ent,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tuser,
  output logic       out_tlast
);

  logic       vld_r;
  logic [1:0] idx_r, idx_nxt;
  sed_slot_t  slot_r;
  logic       load, last_slot;

  assign load      = hd_valid && (!vld_r || out_tready);
  assign last_slot = (idx_r == hd_ent.cnt - 2'd1);
  assign pop       = load && last_slot;
  assign idx_nxt   = last_slot ? 2'd0 : idx_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      if (load) begin
        vld_r <= 1'b1;
        idx_r <= idx_nxt;
      end else if (out_tready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= hd_ent.slot[idx_r];
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = slot_r.data;
  assign out_tuser  = slot_r.valid;
  assign out_tlast  = slot_r.eos;

endmodule

[rtl/string_escape_decoder.sv]
// channel  | signals                               | payload
// in_      | tvalid tready tdata[7:0] tlast        | raw char, end marker
// out_     | tvalid tready tdata[7:0] tuser tlast  | byte, byte valid, end of string
//
// One input transaction per cycle while not full; the state machine decodes it on accept.
// An input gives up to three results; the output stage sends one per cycle unless stalled.
// The result queue holds FIFO_DEPTH decoded transactions; in_tready drops when it is full.
// rst_n is synchronous, active low.
module string_escape_decoder
  import sed_pkg::*;
#(
  parameter int FIFO_DEPTH = SED_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] byte_valid
  output logic       out_tlast
);

  logic       acc, push, full, hd_valid, pop;
  sed_entry_t ent, hd_ent;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  sed_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .in_char  (in_tdata),
    .end_mark (in_tlast),
    .push     (push),
    .ent      (ent)
  );

  sed_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_ent   (ent),
    .full     (full),
    .pop      (pop),
    .rd_valid (hd_valid),
    .rd_ent   (hd_ent)
  );

  sed_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .hd_valid   (hd_valid),
    .hd_ent     (hd_ent),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[rtl/sed_checker.sv]
`include "string_escape_decoder_macros.svh"

module sed_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  `SED_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "output changed while stalled")

  `SED_ASSERT_NOW(a_term_zero, out_tvalid && out_tlast, !out_tuser && (out_tdata == 8'h00), "terminator carries data")

  `SED_ASSERT_NOW(a_byte_flag, out_tvalid && !out_tlast, out_tuser, "non-terminator without byte flag")

endmodule

bind string_escape_decoder sed_checker u_sed_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[bench/string_escape_checker.sv]
`timescale 1ns / 100ps

module string_escape_checker
  import sed_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [7:0] out_byte
  input  logic       out_tuser,  // [0] byte_valid
  input  logic       out_tlast,
  output int         fail_count,
  output int         pending
);

  sed_mode_t  mode;
  logic [7:0] held;
  sed_slot_t  decoded_q[$];

  task automatic emit(input logic [7:0] b, input logic v, input logic e);
    sed_slot_t s;
    s.data  = b;
    s.valid = v;
    s.eos   = e;
    decoded_q.insert(decoded_q.size(), s);
  endtask

  function automatic int hex_value(input logic [7:0] c);
    if (c >= CHR_0 && c <= CHR_9) return int'(c - CHR_0);
    if (c >= CHR_A_UP && c <= CHR_F_UP) return int'(c - CHR_A_UP) + 10;
    if (c >= CHR_A_LO && c <= CHR_F_LO) return int'(c - CHR_A_LO) + 10;
    return -1;
  endfunction

  function automatic logic octal_digit(input logic [7:0] c);
    return c >= CHR_0 && c <= CHR_7;
  endfunction

  task automatic take_plain(input logic [7:0] c);
    if (c == CHR_BSLASH) begin
      mode = MODE_ESC;
    end else begin
      mode = MODE_PLAIN;
      emit(c, 1'b1, 1'b0);
    end
  endtask

  task automatic take_escape(input logic [7:0] c);
    mode = MODE_PLAIN;
    case (c)
      CHR_N: emit(BYTE_LF, 1'b1, 1'b0);
      CHR_R: emit(BYTE_CR, 1'b1, 1'b0);
      CHR_T: emit(BYTE_HT, 1'b1, 1'b0);
      CHR_F: emit(BYTE_FF, 1'b1, 1'b0);
      CHR_V: emit(BYTE_VT, 1'b1, 1'b0);
      CHR_DQUOTE, CHR_BTICK, CHR_BSLASH: emit(c, 1'b1, 1'b0);
      CHR_X_LO, CHR_X_UP: begin
        mode = MODE_HEX0;
        held = c;
      end
      default: begin
        if (octal_digit(c)) begin
          mode = MODE_OCT1;
          held = c - CHR_0;
        end else begin
          emit(CHR_BSLASH, 1'b1, 1'b0);
          emit(c, 1'b1, 1'b0);
        end
      end
    endcase
  endtask

  task automatic decode_item(input logic [7:0] c, input logic endm);
    int h;
    if (endm) begin
      case (mode)
        MODE_ESC: emit(CHR_BSLASH, 1'b1, 1'b0);
        MODE_HEX0: begin
          emit(CHR_BSLASH, 1'b1, 1'b0);
          emit(held, 1'b1, 1'b0);
        end
        MODE_HEX1, MODE_OCT1, MODE_OCT2: emit(held, 1'b1, 1'b0);
        default: ;
      endcase
      emit(8'h00, 1'b0, 1'b1);
      mode = MODE_PLAIN;
      held = '0;
    end else begin
      h = hex_value(c);
      case (mode)
        MODE_ESC: take_escape(c);
        MODE_HEX0: begin
          if (h >= 0) begin
            mode = MODE_HEX1;
            held = 8'(h);
          end else begin
            emit(CHR_BSLASH, 1'b1, 1'b0);
            emit(held, 1'b1, 1'b0);
            take_plain(c);
          end
        end
        MODE_HEX1: begin
          if (h >= 0) begin
            emit({held[3:0], 4'(h)}, 1'b1, 1'b0);
            mode = MODE_PLAIN;
          end else begin
            emit(held, 1'b1, 1'b0);
            take_plain(c);
          end
        end
        MODE_OCT1: begin
          if (octal_digit(c)) begin
            held = 8'((held << 3) | (c - CHR_0));
            mode = MODE_OCT2;
          end else begin
            emit(held, 1'b1, 1'b0);
            take_plain(c);
          end
        end
        MODE_OCT2: begin
          if (octal_digit(c)) begin
            emit(8'((held << 3) | (c - CHR_0)), 1'b1, 1'b0);
            mode = MODE_PLAIN;
          end else begin
            emit(held, 1'b1, 1'b0);
            take_plain(c);
          end
        end
        default: take_plain(c);
      endcase
    end
  endtask

  always @(posedge clk) begin
    sed_slot_t want;
    if (!rst_n) begin
      mode = MODE_PLAIN;
      held = '0;
      decoded_q.delete();
      fail_count = 0;
    end else begin
      // retire results before queuing new ones; latency keeps them apart
      if (out_tvalid && out_tready) begin
        if (decoded_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result byte %h valid %b eos %b",
                     $realtime, out_tdata, out_tuser, out_tlast);
        end else begin
          want = decoded_q.pop_front();
          if (want.data !== out_tdata || want.valid !== out_tuser || want.eos !== out_tlast)
          begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: expected byte %h valid %b eos %b, got byte %h valid %b eos %b",
                       $realtime, want.data, want.valid, want.eos,
                       out_tdata, out_tuser, out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready) decode_item(in_tdata, in_tlast);
    end
    pending = decoded_q.size();
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import sed_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] in_char
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] out_byte
  logic       out_tuser;          // [0] byte_valid
  logic       out_tlast;
  int         fail_count;
  int         pending;

  int burst_left = 0;
  int chars_sent = 0;
  int stall_style = 0;
  int stall_left = 0;
  int cyc = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  string_escape_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  string_escape_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // receiver backpressure: style is redrawn each time stall_left counts down to zero
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left  <= $urandom_range(16, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (cyc % 3) != 0;
      default: out_tready <= $urandom_range(0, 3) == 0;
    endcase
  end

  task automatic send_item(input logic [7:0] c, input logic m);
    int gap;
    logic ready_seen;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= m;
    do begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
    end while (!ready_seen);
    burst_left--;
    chars_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    send_item(c, 1'b0);
  endtask

  function automatic logic [7:0] hex_digit_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return CHR_0 + 8'(r);
    if (r < 16) return CHR_A_LO + 8'(r - 10);
    return CHR_A_UP + 8'(r - 16);
  endfunction

  function automatic logic [7:0] simple_escape_char();
    case ($urandom_range(0, 7))
      0: return CHR_N;
      1: return CHR_R;
      2: return CHR_T;
      3: return CHR_F;
      4: return CHR_V;
      5: return CHR_DQUOTE;
      6: return CHR_BTICK;
      default: return CHR_BSLASH;
    endcase
  endfunction

  task automatic send_token();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      send_char(8'($urandom_range(0, 255)));
    end else if (kind < 45) begin
      send_char(CHR_BSLASH);
      send_char(simple_escape_char());
    end else if (kind < 62) begin
      send_char(CHR_BSLASH);
      send_char($urandom_range(0, 1) ? CHR_X_LO : CHR_X_UP);
      n = $urandom_range(0, 2);
      repeat (n) send_char(hex_digit_char());
    end else if (kind < 80) begin
      send_char(CHR_BSLASH);
      n = $urandom_range(1, 3);
      repeat (n) send_char(CHR_0 + 8'($urandom_range(0, 7)));
    end else if (kind < 90) begin
      send_char(CHR_BSLASH);
      send_char(8'($urandom_range(0, 255)));
    end else begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, each escape form, early ends
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CHR_BSLASH);
    send_char(CHR_N);
    send_char(CHR_BSLASH);
    send_char(CHR_X_LO);
    send_char(CHR_0 + 8'd4);
    send_char(CHR_0 + 8'd1);
    send_char(CHR_BSLASH);
    send_char(CHR_X_UP);
    send_char(8'h47);
    send_char(CHR_BSLASH);
    send_char(CHR_7);
    send_char(CHR_7);
    send_char(CHR_7);
    send_char(CHR_BSLASH);
    send_char(CHR_0 + 8'd1);
    send_char(8'h7A);
    send_char(CHR_BSLASH);
    send_char(CHR_0 + 8'd8);
    send_char(CHR_BSLASH);
    send_item(8'hFF, 1'b1);
    send_char(CHR_BSLASH);
    send_char(CHR_X_LO);
    send_item(8'h00, 1'b1);

    while (chars_sent < 318) send_token();
    send_item(8'($urandom_range(0, 255)), 1'b1);
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
